// ===== rtl/scheduled_tick_timer_queue_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the scheduled tick timer queue
// Clocked on clk and quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SCHEDULED_TICK_TIMER_QUEUE_CORE_MACROS_SVH
`define SCHEDULED_TICK_TIMER_QUEUE_CORE_MACROS_SVH

// Same-cycle implication.
`define STQC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STQC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/stqc_pkg.sv =====
// ----------------------------------------------------------------------------
// stqc_pkg
// Types, codes and defaults shared by the scheduled tick timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package stqc_pkg;

  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int DEF_TYPE_BITS   = 3;
  localparam int TICK_W          = 64;
  localparam int MIN_DELAY       = 1;

  // command kinds
  localparam logic [1:0] KIND_SCHED  = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_ADV    = 2'd3;

  // reply kinds
  localparam logic [1:0] RPL_RELEASE = 2'd0;
  localparam logic [1:0] RPL_SCHED   = 2'd1;
  localparam logic [1:0] RPL_CANCEL  = 2'd2;
  localparam logic [1:0] RPL_QUERY   = 2'd3;

  // cell operations
  localparam logic [2:0] CELL_HOLD   = 3'd0;
  localparam logic [2:0] CELL_INSERT = 3'd1;
  localparam logic [2:0] CELL_CLEAR  = 3'd2;
  localparam logic [2:0] CELL_SHIFT  = 3'd3;
  localparam logic [2:0] CELL_SWAP   = 3'd4;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pos_t;

  typedef struct packed {
    logic [2:0] op;
    logic       lower;
  } cell_ctrl_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        delay;
    logic [2:0]         tick_type;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         reply_kind;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [2:0]         out_type;
    logic               found;
    logic               dropped;
    logic               last;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/stqc_cell.sv =====
// ----------------------------------------------------------------------------
// stqc_cell
// One slot of the sorted timer chain: holds an entry and trades it with its
// neighbors on insert, release shift and compaction swaps.
// ----------------------------------------------------------------------------
`default_nettype none

module stqc_cell #(
  parameter int TYPE_BITS = stqc_pkg::DEF_TYPE_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire stqc_pkg::cell_ctrl_t        ctrl,
  input  wire logic [stqc_pkg::TICK_W-1:0] key_due,
  input  wire stqc_pkg::pos_t              key_pos,
  input  wire logic [TYPE_BITS-1:0]        key_type,
  input  wire logic                        prev_gt,
  input  wire logic                        prev_valid,
  input  wire logic [stqc_pkg::TICK_W-1:0] prev_due,
  input  wire stqc_pkg::pos_t              prev_pos,
  input  wire logic [TYPE_BITS-1:0]        prev_type,
  input  wire logic                        next_valid,
  input  wire logic [stqc_pkg::TICK_W-1:0] next_due,
  input  wire stqc_pkg::pos_t              next_pos,
  input  wire logic [TYPE_BITS-1:0]        next_type,
  output logic                             valid,
  output logic [stqc_pkg::TICK_W-1:0]      due,
  output stqc_pkg::pos_t                   pos,
  output logic [TYPE_BITS-1:0]             ttype,
  output logic                             gt,
  output logic                             match
);

  logic                        valid_r, valid_nxt;
  logic [stqc_pkg::TICK_W-1:0] due_r, due_nxt;
  stqc_pkg::pos_t              pos_r, pos_nxt;
  logic [TYPE_BITS-1:0]        type_r, type_nxt;

  // key goes below this slot when the slot is empty or due later
  assign gt    = !valid_r || (due_r > key_due);
  assign match = valid_r && (pos_r == key_pos);

  assign valid = valid_r;
  assign due   = due_r;
  assign pos   = pos_r;
  assign ttype = type_r;

  always_comb begin
    valid_nxt = valid_r;
    due_nxt   = due_r;
    pos_nxt   = pos_r;
    type_nxt  = type_r;
    unique case (ctrl.op)
      stqc_pkg::CELL_HOLD: begin
      end
      stqc_pkg::CELL_INSERT: begin
        if (gt) begin
          if (prev_gt) begin
            valid_nxt = prev_valid;
            due_nxt   = prev_due;
            pos_nxt   = prev_pos;
            type_nxt  = prev_type;
          end else begin
            valid_nxt = 1'b1;
            due_nxt   = key_due;
            pos_nxt   = key_pos;
            type_nxt  = key_type;
          end
        end
      end
      stqc_pkg::CELL_CLEAR: begin
        if (match) begin
          valid_nxt = 1'b0;
        end
      end
      stqc_pkg::CELL_SHIFT: begin
        valid_nxt = next_valid;
        due_nxt   = next_due;
        pos_nxt   = next_pos;
        type_nxt  = next_type;
      end
      stqc_pkg::CELL_SWAP: begin
        if (ctrl.lower) begin
          // pull the upper partner down into an empty slot
          if (!valid_r && next_valid) begin
            valid_nxt = 1'b1;
            due_nxt   = next_due;
            pos_nxt   = next_pos;
            type_nxt  = next_type;
          end
        end else begin
          if (!prev_valid && valid_r) begin
            valid_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    due_r  <= due_nxt;
    pos_r  <= pos_nxt;
    type_r <= type_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/scheduled_tick_timer_queue_core.sv =====
// Schedule and query: the result is registered out of the ST_OP state; the block is busy
//   in ST_OP and takes no new command until it is back in idle. The receiver cannot stall.
// Cancel: ack as above while odd-even swap passes compact the chain; busy until no hole
//   sits below a live entry.
// Advance: the tick bumps at the accepting edge, then one release per cycle from the chain
//   head, busy until the head is no longer due. Synchronous reset clears tick and valid bits.
// ----------------------------------------------------------------------------
// scheduled_tick_timer_queue_core
// Timed event queue kept as a chain of cells sorted by due time, with
// insertion order breaking ties; the head cell is released first.
// ----------------------------------------------------------------------------
`default_nettype none

module scheduled_tick_timer_queue_core #(
  parameter int QUEUE_DEPTH = stqc_pkg::DEF_QUEUE_DEPTH,
  parameter int TYPE_BITS   = stqc_pkg::DEF_TYPE_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire stqc_pkg::in_item_t in_item,
  output logic                    out_valid,
  output stqc_pkg::out_item_t     out_item
);

  localparam int TW = stqc_pkg::TICK_W;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_OP   = 2'd1;
  localparam logic [1:0] ST_REL  = 2'd2;
  localparam logic [1:0] ST_PACK = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [TW-1:0]       tick_r, tick_nxt;
  logic                phase_r, phase_nxt;
  logic                out_valid_r, out_valid_nxt;
  stqc_pkg::out_item_t out_item_r, out_item_nxt;

  // latched command
  logic [1:0]           cmd_kind_r;
  stqc_pkg::pos_t       cmd_pos_r;
  logic [TW-1:0]        cmd_due_r;
  logic [TYPE_BITS-1:0] cmd_type_r;

  logic          accept;
  logic [15:0]   eff_delay;
  logic [2:0]    cell_op;

  // chain views
  logic [QUEUE_DEPTH-1:0] valid_vec, gt_vec, match_vec;
  logic [QUEUE_DEPTH-1:0] prev_gt_vec, prev_valid_vec, next_valid_vec;
  logic [TW-1:0]          due_a       [QUEUE_DEPTH];
  stqc_pkg::pos_t         pos_a       [QUEUE_DEPTH];
  logic [TYPE_BITS-1:0]   type_a      [QUEUE_DEPTH];
  logic [TW-1:0]          prev_due_a  [QUEUE_DEPTH];
  stqc_pkg::pos_t         prev_pos_a  [QUEUE_DEPTH];
  logic [TYPE_BITS-1:0]   prev_type_a [QUEUE_DEPTH];
  logic [TW-1:0]          next_due_a  [QUEUE_DEPTH];
  stqc_pkg::pos_t         next_pos_a  [QUEUE_DEPTH];
  logic [TYPE_BITS-1:0]   next_type_a [QUEUE_DEPTH];
  stqc_pkg::cell_ctrl_t   ctrl_a      [QUEUE_DEPTH];

  logic full, ripe0, ripe1, need_pack;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Valid entries always form a sorted prefix outside a compaction pass,
  // so the top slot tells fullness and the head slots tell what is due.
  assign full      = valid_vec[QUEUE_DEPTH-1];
  assign ripe0     = valid_vec[0] && (due_a[0] <= tick_r);
  assign ripe1     = valid_vec[1] && (due_a[1] <= tick_r);
  assign need_pack = |(~valid_vec[QUEUE_DEPTH-2:0] & valid_vec[QUEUE_DEPTH-1:1]);

  assign eff_delay = (in_item.delay == '0) ? 16'(stqc_pkg::MIN_DELAY) : in_item.delay;

  // Wire each slot to its neighbors; the top end reads as empty, the bottom end as valid.
  assign prev_gt_vec    = {gt_vec[QUEUE_DEPTH-2:0], 1'b0};
  assign prev_valid_vec = {valid_vec[QUEUE_DEPTH-2:0], 1'b1};
  assign next_valid_vec = {1'b0, valid_vec[QUEUE_DEPTH-1:1]};

  always_comb begin
    prev_due_a[0]  = '0;
    prev_pos_a[0]  = '0;
    prev_type_a[0] = '0;
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      prev_due_a[i]  = due_a[i-1];
      prev_pos_a[i]  = pos_a[i-1];
      prev_type_a[i] = type_a[i-1];
    end
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      next_due_a[i]  = due_a[i+1];
      next_pos_a[i]  = pos_a[i+1];
      next_type_a[i] = type_a[i+1];
    end
    next_due_a[QUEUE_DEPTH-1]  = '0;
    next_pos_a[QUEUE_DEPTH-1]  = '0;
    next_type_a[QUEUE_DEPTH-1] = '0;
  end

  // Broadcast the operation; the swap phase picks which slot of a pair is lower.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ctrl_a[i].op    = cell_op;
      ctrl_a[i].lower = (1'(i) == phase_r);
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    stqc_cell #(
      .TYPE_BITS (TYPE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl_a[g]),
      .key_due    (cmd_due_r),
      .key_pos    (cmd_pos_r),
      .key_type   (cmd_type_r),
      .prev_gt    (prev_gt_vec[g]),
      .prev_valid (prev_valid_vec[g]),
      .prev_due   (prev_due_a[g]),
      .prev_pos   (prev_pos_a[g]),
      .prev_type  (prev_type_a[g]),
      .next_valid (next_valid_vec[g]),
      .next_due   (next_due_a[g]),
      .next_pos   (next_pos_a[g]),
      .next_type  (next_type_a[g]),
      .valid      (valid_vec[g]),
      .due        (due_a[g]),
      .pos        (pos_a[g]),
      .ttype      (type_a[g]),
      .gt         (gt_vec[g]),
      .match      (match_vec[g])
    );
  end

  // Sequencer: each command runs in ST_OP, one release per cycle on advance,
  // and swap passes after a cancel until no hole sits below a live entry.
  always_comb begin
    state_nxt     = state_r;
    tick_nxt      = tick_r;
    phase_nxt     = phase_r;
    cell_op       = stqc_pkg::CELL_HOLD;
    out_valid_nxt = 1'b0;

    // default reply: echo the command position, last set, no other flags
    out_item_nxt            = '0;
    out_item_nxt.out_x      = cmd_pos_r.x;
    out_item_nxt.out_y      = cmd_pos_r.y;
    out_item_nxt.out_z      = cmd_pos_r.z;
    out_item_nxt.last       = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.kind == stqc_pkg::KIND_ADV) begin
            tick_nxt  = tick_r + TW'(1);
            state_nxt = ST_REL;
          end else begin
            state_nxt = ST_OP;
          end
        end
      end
      ST_OP: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
        unique case (cmd_kind_r)
          stqc_pkg::KIND_SCHED: begin
            out_item_nxt.reply_kind = stqc_pkg::RPL_SCHED;
            out_item_nxt.dropped    = full;
            if (!full) begin
              cell_op = stqc_pkg::CELL_INSERT;
            end
          end
          stqc_pkg::KIND_CANCEL: begin
            out_item_nxt.reply_kind = stqc_pkg::RPL_CANCEL;
            cell_op                 = stqc_pkg::CELL_CLEAR;
            phase_nxt               = 1'b0;
            state_nxt               = ST_PACK;
          end
          stqc_pkg::KIND_QUERY: begin
            out_item_nxt.reply_kind = stqc_pkg::RPL_QUERY;
            out_item_nxt.found      = |match_vec;
          end
          stqc_pkg::KIND_ADV: begin
            // advance never takes this path; drop it quietly
            out_valid_nxt = 1'b0;
          end
        endcase
      end
      ST_REL: begin
        if (ripe0) begin
          // release the head and advance the chain by one slot
          cell_op                 = stqc_pkg::CELL_SHIFT;
          out_valid_nxt           = 1'b1;
          out_item_nxt.reply_kind = stqc_pkg::RPL_RELEASE;
          out_item_nxt.out_x      = pos_a[0].x;
          out_item_nxt.out_y      = pos_a[0].y;
          out_item_nxt.out_z      = pos_a[0].z;
          out_item_nxt.out_type   = 3'(type_a[0]);
          out_item_nxt.last       = !ripe1;
          if (!ripe1) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PACK: begin
        if (need_pack) begin
          cell_op   = stqc_pkg::CELL_SWAP;
          phase_nxt = !phase_r;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the command on accept; the due time uses the tick before any advance.
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (accept) begin
      cmd_kind_r  <= in_item.kind;
      cmd_pos_r.x <= in_item.pos_x;
      cmd_pos_r.y <= in_item.pos_y;
      cmd_pos_r.z <= in_item.pos_z;
      cmd_due_r   <= tick_r + TW'(eff_delay);
      cmd_type_r  <= TYPE_BITS'(in_item.tick_type);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/stqc_checker.sv =====
// ----------------------------------------------------------------------------
// stqc_checker
// Port-level checks of the timer queue's result flags and busy behavior.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scheduled_tick_timer_queue_core_macros.svh"

module stqc_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_valid,
  input wire stqc_pkg::out_item_t out_item
);

  `STQC_ASSERT_IMP(a_ack_last, out_valid && out_item.reply_kind != stqc_pkg::RPL_RELEASE, out_item.last, "ack or answer without last")
  `STQC_ASSERT_IMP(a_found_query, out_valid && out_item.found, out_item.reply_kind == stqc_pkg::RPL_QUERY, "found outside a query answer")
  `STQC_ASSERT_IMP(a_drop_sched, out_valid && out_item.dropped, out_item.reply_kind == stqc_pkg::RPL_SCHED, "dropped outside a schedule ack")
  `STQC_ASSERT_IMP(a_type_zero, out_valid && out_item.reply_kind != stqc_pkg::RPL_RELEASE, out_item.out_type == 3'd0, "tick type on a non-release result")
  `STQC_ASSERT_NXT(a_busy_after, start && !busy, busy, "no busy after an accepted transaction")

endmodule

bind scheduled_tick_timer_queue_core stqc_checker u_stqc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire
